@@ rtl/hap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hap_pkg
// Shared types for the handle allocator: operation codes, status codes and
// the controller states.
// ----------------------------------------------------------------------------
package hap_pkg;

    typedef enum logic [2:0] {
        OP_CREATE      = 3'd0,
        OP_DESTROY     = 3'd1,
        OP_SET_CURRENT = 3'd2,
        OP_GET_CURRENT = 3'd3,
        OP_LOOKUP      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_LIVE   = 2'd2,
        ST_NO_CURRENT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_READ2,
        S_FIX,
        S_DONE
    } state_t;

endpackage

@@ rtl/hap_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hap_ram
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module hap_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 5,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/handle_allocator_packed_table.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted input beat steps through S_READ, S_EVAL and S_DONE;
// a destroy of the current handle that must fetch the entry below the last one
// also steps through S_READ2 and S_FIX. A new item is taken only in S_IDLE,
// after the last result is registered; S_DONE holds until the previous is taken.
// Reset: after rst_n releases, a clearing pass over all MAX_ENTRIES ids refills
// the free id queue and clears the live flags; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
// handle_allocator_packed_table
// Handle allocator over a packed table: free id queue, packed id array,
// id-to-position map and live flags, each held in a synchronous memory.
// ----------------------------------------------------------------------------
module handle_allocator_packed_table #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op,
    input  logic [4:0] entry_id,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [4:0] result_id,
    output logic [4:0] result_position,
    output logic [5:0] live_count
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    hap_pkg::state_t  state_reg, state_next;
    logic [IW-1:0]    clr_reg, clr_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    hap_pkg::op_t     op_reg, op_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             range_reg, range_next;
    hap_pkg::status_t res_status_reg, res_status_next;
    logic [IW-1:0]    res_id_reg, res_id_next;
    logic [IW-1:0]    res_pos_reg, res_pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [4:0]       result_id_reg, result_id_next;
    logic [4:0]       result_pos_reg, result_pos_next;
    logic [5:0]       live_count_reg, live_count_next;

    // memory ports
    logic          fifo_we, packed_we, posmap_we, live_we;
    logic [IW-1:0] fifo_waddr, packed_waddr, posmap_waddr, live_waddr;
    logic [IW-1:0] fifo_wdata, packed_wdata, posmap_wdata;
    logic          live_wdata;
    logic [IW-1:0] tgt_addr, last_addr;
    logic [IW-1:0] fifo_rdata, packed_rdata, posmap_rdata;
    logic          live_rdata;

    logic [IW-1:0] last_idx;
    logic          cur_hit;
    logic [31:0]   id_wide, pos_wide, cnt_wide;

    hap_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(IW)) u_free_fifo (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

    hap_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(IW)) u_packed_ids (
        .clk   (clk),
        .we    (packed_we),
        .waddr (packed_waddr),
        .wdata (packed_wdata),
        .raddr (last_addr),
        .rdata (packed_rdata)
    );

    hap_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(IW)) u_position_of (
        .clk   (clk),
        .we    (posmap_we),
        .waddr (posmap_waddr),
        .wdata (posmap_wdata),
        .raddr (tgt_addr),
        .rdata (posmap_rdata)
    );

    hap_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(1)) u_live_flags (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (tgt_addr),
        .rdata (live_rdata)
    );

    // get_current looks at the current handle, everything else at the named id
    assign tgt_addr  = (op_reg == hap_pkg::OP_GET_CURRENT) ? cur_reg : idx_reg;
    // after a destroy the count has dropped, so this also gives the old last - 1
    assign last_addr = IW'(count_reg - 1'b1);
    assign last_idx  = IW'(count_reg - 1'b1);
    assign cur_hit   = cur_valid_reg && (cur_reg == idx_reg);

    assign in_ready        = (state_reg == hap_pkg::S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign result_id       = result_id_reg;
    assign result_position = result_pos_reg;
    assign live_count      = live_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hap_pkg::S_INIT;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        range_reg      <= range_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_pos_reg    <= res_pos_next;
        status_reg     <= status_next;
        result_id_reg  <= result_id_next;
        result_pos_reg <= result_pos_next;
        live_count_reg <= live_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        cur_valid_next  = cur_valid_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        range_next      = range_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        result_id_next  = result_id_reg;
        result_pos_next = result_pos_reg;
        live_count_next = live_count_reg;

        fifo_we      = 1'b0;
        fifo_waddr   = tail_reg;
        fifo_wdata   = idx_reg;
        packed_we    = 1'b0;
        packed_waddr = IW'(count_reg);
        packed_wdata = fifo_rdata;
        posmap_we    = 1'b0;
        posmap_waddr = fifo_rdata;
        posmap_wdata = IW'(count_reg);
        live_we      = 1'b0;
        live_waddr   = fifo_rdata;
        live_wdata   = 1'b1;

        id_wide  = 32'(res_id_reg);
        pos_wide = 32'(res_pos_reg);
        cnt_wide = 32'(count_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            hap_pkg::S_INIT:
            begin
                // free queue holds 0..N-1, no id is live
                fifo_we    = 1'b1;
                fifo_waddr = clr_reg;
                fifo_wdata = clr_reg;
                live_we    = 1'b1;
                live_waddr = clr_reg;
                live_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == IW'(MAX_ENTRIES - 1))
                begin
                    state_next = hap_pkg::S_IDLE;
                end
            end

            hap_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = hap_pkg::op_t'(op);
                    idx_next   = IW'(entry_id);
                    range_next = (32'(entry_id) < MAX_ENTRIES);
                    state_next = hap_pkg::S_READ;
                end
            end

            hap_pkg::S_READ:
            begin
                state_next = hap_pkg::S_EVAL;
            end

            hap_pkg::S_EVAL:
            begin
                state_next      = hap_pkg::S_DONE;
                res_status_next = hap_pkg::ST_OK;
                res_id_next     = '0;
                res_pos_next    = '0;
                case (op_reg)
                    hap_pkg::OP_CREATE:
                    begin
                        if (count_reg == CW'(MAX_ENTRIES))
                        begin
                            res_status_next = hap_pkg::ST_FULL;
                        end
                        else
                        begin
                            packed_we      = 1'b1;
                            posmap_we      = 1'b1;
                            live_we        = 1'b1;
                            head_next      = (head_reg == IW'(MAX_ENTRIES - 1)) ?
                                             '0 : head_reg + 1'b1;
                            count_next     = count_reg + 1'b1;
                            cur_next       = fifo_rdata;
                            cur_valid_next = 1'b1;
                            res_id_next    = fifo_rdata;
                            res_pos_next   = IW'(count_reg);
                        end
                    end

                    hap_pkg::OP_DESTROY:
                    begin
                        if (!range_reg || !live_rdata || count_reg == '0)
                        begin
                            res_status_next = hap_pkg::ST_NOT_LIVE;
                        end
                        else
                        begin
                            // move the last entry into the hole; harmless when
                            // the hole is the last entry itself
                            packed_we    = 1'b1;
                            packed_waddr = posmap_rdata;
                            packed_wdata = packed_rdata;
                            posmap_we    = 1'b1;
                            posmap_waddr = packed_rdata;
                            posmap_wdata = posmap_rdata;
                            live_we      = 1'b1;
                            live_waddr   = idx_reg;
                            live_wdata   = 1'b0;
                            fifo_we      = 1'b1;
                            tail_next    = (tail_reg == IW'(MAX_ENTRIES - 1)) ?
                                           '0 : tail_reg + 1'b1;
                            count_next   = count_reg - 1'b1;
                            res_id_next  = idx_reg;
                            res_pos_next = posmap_rdata;
                            if (cur_hit)
                            begin
                                if (posmap_rdata != last_idx)
                                begin
                                    cur_next = packed_rdata;
                                end
                                else if (last_idx != '0)
                                begin
                                    // need the entry below the old last one
                                    state_next = hap_pkg::S_READ2;
                                end
                                else
                                begin
                                    cur_valid_next = 1'b0;
                                end
                            end
                        end
                    end

                    hap_pkg::OP_SET_CURRENT:
                    begin
                        if (range_reg && live_rdata)
                        begin
                            cur_next       = idx_reg;
                            cur_valid_next = 1'b1;
                            res_id_next    = idx_reg;
                            res_pos_next   = posmap_rdata;
                        end
                        else
                        begin
                            res_status_next = hap_pkg::ST_NOT_LIVE;
                        end
                    end

                    hap_pkg::OP_GET_CURRENT:
                    begin
                        if (cur_valid_reg && live_rdata)
                        begin
                            res_id_next  = cur_reg;
                            res_pos_next = posmap_rdata;
                        end
                        else
                        begin
                            res_status_next = hap_pkg::ST_NO_CURRENT;
                        end
                    end

                    hap_pkg::OP_LOOKUP:
                    begin
                        if (range_reg && live_rdata)
                        begin
                            res_id_next  = idx_reg;
                            res_pos_next = posmap_rdata;
                        end
                        else
                        begin
                            res_status_next = hap_pkg::ST_NOT_LIVE;
                        end
                    end

                    default:
                    begin
                        res_status_next = hap_pkg::ST_OK;
                    end
                endcase
            end

            hap_pkg::S_READ2:
            begin
                state_next = hap_pkg::S_FIX;
            end

            hap_pkg::S_FIX:
            begin
                cur_next   = packed_rdata;
                state_next = hap_pkg::S_DONE;
            end

            hap_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    result_id_next  = id_wide[4:0];
                    result_pos_next = pos_wide[4:0];
                    live_count_next = cnt_wide[5:0];
                    state_next      = hap_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = hap_pkg::S_IDLE;
            end
        endcase
    end

endmodule
